// ----- design/cwbb_pkg.sv -----
package cwbb_pkg;

    // Register byte addresses on the configuration port
    localparam logic [2:0] ADDR_RADIUS = 3'h0;
    localparam logic [2:0] ADDR_HEIGHT = 3'h4;

    localparam logic [30:0] RADIUS_RESET = 31'd32768;
    localparam logic [30:0] HEIGHT_RESET = 31'd131072;

    // Root bits resolved per pipeline stage, and stages in the root pipe
    localparam int ROOT_BITS_PER_STAGE = 2;
    localparam int ROOT_STAGES         = 32 / ROOT_BITS_PER_STAGE;

    // One column's digit-by-digit square root in flight
    typedef struct packed {
        logic [35:0] rem;
        logic [31:0] q;
        logic [63:0] n;
    } root_t;

    // Per-item values carried alongside the root pipe
    typedef struct packed {
        logic [2:0][62:0]        half;
        logic [2:0][31:0]        shift;
    } carry_t;

    function automatic root_t root_step(input root_t s);
        logic [35:0] r;
        logic [35:0] t;
        root_t       o;
        r = {s.rem[33:0], s.n[63:62]};
        t = {2'b00, s.q, 2'b01};
        o.n = {s.n[61:0], 2'b00};
        if (r >= t)
        begin
            o.rem = r - t;
            o.q   = {s.q[30:0], 1'b1};
        end
        else
        begin
            o.rem = r;
            o.q   = {s.q[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] o;
        if (v > 66'sd2147483647)
            o = 32'h7FFF_FFFF;
        else if (v < -66'sd2147483648)
            o = 32'h8000_0000;
        else
            o = v[31:0];
        return o;
    endfunction

endpackage

// ----- design/capsule_world_bounding_box.sv -----
// Capsule world bounding box.
//
// Input channel: in_valid / in_stall carry one beat per transform: the upper
// three rows of the first three matrix columns (col0_*, col1_*, col2_*) and
// the translation column (shift_*), all signed Q(32-FRAC_BITS).FRAC_BITS.
// Output channel: out_valid / out_stall carry one beat per input beat with the
// box corners low_* and high_*, saturated to 32-bit signed fixed point.
// Capsule radius and total height sit in two APB registers (byte address 0
// and 4); write them only while no beat is in flight.
//
// Throughput: one beat per cycle while out_stall stays low. Depth: 21 register
// stages, set by the two-bits-per-stage square root pipe (16 stages) that finds
// the column lengths, plus square, sum, max, radius-scale and output stages.
//
// Reset clears every stage valid and loads the register defaults (radius 0.5,
// height 2.0). When the receiver stalls, the output beat holds; stages behind
// it keep advancing into empty slots and in_stall rises only once the pipe
// is full up to the input.
module capsule_world_bounding_box #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] col0_x,
    input  logic [31:0] col0_y,
    input  logic [31:0] col0_z,
    input  logic [31:0] col1_x,
    input  logic [31:0] col1_y,
    input  logic [31:0] col1_z,
    input  logic [31:0] col2_x,
    input  logic [31:0] col2_y,
    input  logic [31:0] col2_z,
    input  logic [31:0] shift_x,
    input  logic [31:0] shift_y,
    input  logic [31:0] shift_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] low_x,
    output logic [31:0] low_y,
    output logic [31:0] low_z,
    output logic [31:0] high_x,
    output logic [31:0] high_y,
    output logic [31:0] high_z
);
    import cwbb_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [30:0] radius_reg;
    logic [30:0] height_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Decode on address bit 2 only: every write lands in one of the two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ADDR_HEIGHT[2])
                height_reg <= pwdata[30:0];
            else
                radius_reg <= pwdata[30:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_HEIGHT[2]) ? {1'b0, height_reg} : {1'b0, radius_reg};

    // Cylinder length: height minus twice radius, clamped at zero
    logic [32:0] cyl_diff;
    logic [30:0] cyl;
    assign cyl_diff = {2'b00, height_reg} - {1'b0, radius_reg, 1'b0};
    assign cyl      = cyl_diff[32] ? 31'd0 : cyl_diff[30:0];

    // ---------------------------------------------------------------
    // Stage ready chain: a stage loads when empty or its successor moves
    // ---------------------------------------------------------------
    logic                  v1_reg, v2_reg, vm_reg, vr_reg, out_valid_reg;
    logic [ROOT_STAGES-1:0] vs_reg;
    logic                  rdy_out, rdy_r, rdy_m, rdy2, rdy1;
    logic [ROOT_STAGES:0]  rdy_s;

    assign rdy_out = !out_valid_reg || !out_stall;
    assign rdy_r   = !vr_reg || rdy_out;
    assign rdy_m   = !vm_reg || rdy_r;
    assign rdy_s[ROOT_STAGES] = rdy_m;
    assign rdy2    = !v2_reg || rdy_s[0];
    assign rdy1    = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    // ---------------------------------------------------------------
    // Stage 1: squares of columns 0 and 2, axis half extents
    // ---------------------------------------------------------------
    logic [5:0][63:0] sq_reg;
    carry_t           c1_reg;
    logic [5:0][31:0] sq_in;
    logic [2:0][31:0] ax_in;
    logic [2:0][31:0] sh_in;

    assign sq_in = {mag32(col2_z), mag32(col2_y), mag32(col2_x),
                    mag32(col0_z), mag32(col0_y), mag32(col0_x)};
    assign ax_in = {mag32(col1_z), mag32(col1_y), mag32(col1_x)};
    assign sh_in = {shift_z, shift_y, shift_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (rdy1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            for (int i = 0; i < 6; i++)
                sq_reg[i] <= 64'(sq_in[i]) * 64'(sq_in[i]);
            for (int k = 0; k < 3; k++)
            begin
                c1_reg.half[k]  <= (63'(ax_in[k]) * 63'(cyl)) >> (FRAC_BITS + 1);
                c1_reg.shift[k] <= sh_in[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: sums of squares, seed the root pipe
    // ---------------------------------------------------------------
    root_t  r0_2_reg, r2_2_reg;
    carry_t c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (rdy2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            r0_2_reg.rem <= '0;
            r0_2_reg.q   <= '0;
            r0_2_reg.n   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            r2_2_reg.rem <= '0;
            r2_2_reg.q   <= '0;
            r2_2_reg.n   <= sq_reg[3] + sq_reg[4] + sq_reg[5];
            c2_reg       <= c1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Root pipe: two result bits per stage for both column lengths
    // ---------------------------------------------------------------
    root_t  rs0_reg [ROOT_STAGES];
    root_t  rs2_reg [ROOT_STAGES];
    carry_t cs_reg  [ROOT_STAGES];

    genvar g;
    generate
        for (g = 0; g < ROOT_STAGES; g++)
        begin : g_root
            logic   src_v;
            root_t  src0, src2;
            carry_t src_c;
            root_t  mid0, mid2;

            if (g == 0)
            begin : g_first
                assign src_v = v2_reg;
                assign src0  = r0_2_reg;
                assign src2  = r2_2_reg;
                assign src_c = c2_reg;
            end
            else
            begin : g_next
                assign src_v = vs_reg[g-1];
                assign src0  = rs0_reg[g-1];
                assign src2  = rs2_reg[g-1];
                assign src_c = cs_reg[g-1];
            end

            assign rdy_s[g] = !vs_reg[g] || rdy_s[g+1];
            assign mid0     = root_step(src0);
            assign mid2     = root_step(src2);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vs_reg[g] <= 1'b0;
                else if (rdy_s[g])
                    vs_reg[g] <= src_v;
            end

            always_ff @(posedge clk)
            begin
                if (rdy_s[g] && src_v)
                begin
                    rs0_reg[g] <= root_step(mid0);
                    rs2_reg[g] <= root_step(mid2);
                    cs_reg[g]  <= src_c;
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Larger of the two column lengths
    // ---------------------------------------------------------------
    logic [31:0] lmax_reg;
    carry_t      cm_reg;
    logic [31:0] len0, len2;

    assign len0 = rs0_reg[ROOT_STAGES-1].q;
    assign len2 = rs2_reg[ROOT_STAGES-1].q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else if (rdy_m)
            vm_reg <= vs_reg[ROOT_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_m && vs_reg[ROOT_STAGES-1])
        begin
            lmax_reg <= (len0 > len2) ? len0 : len2;
            cm_reg   <= cs_reg[ROOT_STAGES-1];
        end
    end

    // ---------------------------------------------------------------
    // World radius: radius scaled by the longer column
    // ---------------------------------------------------------------
    logic [62:0] wr_reg;
    carry_t      cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vr_reg <= 1'b0;
        else if (rdy_r)
            vr_reg <= vm_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_r && vm_reg)
        begin
            wr_reg <= (63'(radius_reg) * 63'(lmax_reg)) >> FRAC_BITS;
            cr_reg <= cm_reg;
        end
    end

    // ---------------------------------------------------------------
    // Output: grow the translation by half extent plus radius, saturate
    // ---------------------------------------------------------------
    logic [2:0][31:0]        lo_reg, hi_reg;
    logic signed [2:0][65:0] lo_sum, hi_sum;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_sum[k] = $signed({{34{cr_reg.shift[k][31]}}, cr_reg.shift[k]})
                      - $signed({3'b000, cr_reg.half[k]})
                      - $signed({3'b000, wr_reg});
            hi_sum[k] = $signed({{34{cr_reg.shift[k][31]}}, cr_reg.shift[k]})
                      + $signed({3'b000, cr_reg.half[k]})
                      + $signed({3'b000, wr_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rdy_out)
            out_valid_reg <= vr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out && vr_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[k] <= sat32(lo_sum[k]);
                hi_reg[k] <= sat32(hi_sum[k]);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign low_x     = lo_reg[0];
    assign low_y     = lo_reg[1];
    assign low_z     = lo_reg[2];
    assign high_x    = hi_reg[0];
    assign high_y    = hi_reg[1];
    assign high_z    = hi_reg[2];

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted beat did not enter the first stage");

    a_cyl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cyl <= height_reg)
        else $error("cylinder length exceeds capsule height");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && out_valid_reg && out_stall)
        else $error("input stalled while a bubble was free");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(lo_reg) && $stable(hi_reg))
        else $error("stalled output beat changed");

endmodule
